/* design/rrts_pkg.sv */
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the scheduler and the ready queue.
`default_nettype none

package rrts_pkg;

  localparam int MaxTasksDef  = 16;
  localparam int BurstBitsDef = 16;

  // Item function codes
  localparam logic FuncAdmit = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // Admit status codes
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StBusy = 2'd1;
  localparam logic [1:0] StZero = 2'd2;

  typedef struct packed {
    logic        func;
    logic [3:0]  task_id;
    logic [15:0] burst;
  } rrts_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ran;
    logic [3:0]  running_id;
    logic        finished;
    logic        preempted;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic [31:0] time_now;
  } rrts_out_t;

  // Ready-queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } rrts_qctl_t;

endpackage

`default_nettype wire

/* design/round_robin_task_scheduler.sv */
// Round-robin task scheduler, one item at a time. Admit and idle tick: the item is
// accepted in S_IDLE and its result loads the output register from S_DONE. Running
// tick: queue RAM read, task RAM read, record write-back, result load, in that order.
// A new item is taken only once the last result is loaded; an output stall holds S_DONE.
// Reset clears pointers, time, quantum (to 2) and task active bits; RAM
// contents are not cleared and are only read for active tasks.
`default_nettype none

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS  = MaxTasksDef,
  parameter int BURST_BITS = BurstBitsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire rrts_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output rrts_out_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  localparam int IdW  = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS + 1);
  localparam int BW   = BURST_BITS;
  localparam int RecW = 2 * BW + 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRD,
    S_TRD,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [7:0]         quantum_q;
  logic [31:0]        time_q;
  logic [7:0]         slice_q;
  logic               pend_valid_q;
  logic [IdW-1:0]     pend_id_q;
  logic [MAX_TASKS-1:0] active_q;
  logic [IdW-1:0]     id_q;
  logic [BW-1:0]      burst_q;
  rrts_out_t          res_q;
  rrts_out_t          res_d;
  logic               out_valid_q;
  logic               out_valid_d;
  rrts_out_t          out_q;
  rrts_out_t          out_d;

  // reduce a 4-bit id modulo the task count
  function automatic logic [IdW-1:0] id_reduce(logic [3:0] v);
    logic [8:0] r;
    r = {5'd0, v};
    for (int k = 0; k < 8; k++) begin
      if (r >= 9'(MAX_TASKS)) begin
        r = r - 9'(MAX_TASKS);
      end
    end
    return r[IdW-1:0];
  endfunction

  logic            in_acc;
  logic [IdW-1:0]  in_id;
  logic [31:0]     burst32;
  logic [BW-1:0]   in_b;
  logic            in_busy;
  logic            in_zero;
  logic            admit_ok;
  logic            is_tick;
  logic            tick_runs;
  rrts_qctl_t      qctl;
  logic [IdW-1:0]  push_id;
  logic [IdW-1:0]  head_id;
  logic [CntW-1:0] q_count;

  logic            t_we;
  logic [IdW-1:0]  t_waddr;
  logic [RecW-1:0] t_wdata;
  logic [RecW-1:0] t_rdata;
  logic [BW-1:0]   t_rem;
  logic [BW-1:0]   t_burst;
  logic [31:0]     t_arrival;
  logic [BW-1:0]   rem_new;
  logic [7:0]      slice_new;
  logic            fin;
  logic            pre;
  logic            out_free;

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_id     = id_reduce(in_data_i.task_id);
  assign burst32   = 32'(in_data_i.burst);
  assign in_b      = burst32[BW-1:0];
  assign in_busy   = active_q[in_id];
  assign in_zero   = (in_b == '0);
  assign admit_ok  = in_acc && (in_data_i.func == FuncAdmit) && !in_busy && !in_zero;
  assign is_tick   = in_acc && (in_data_i.func == FuncTick);
  assign tick_runs = (q_count != '0) || pend_valid_q;

  assign qctl.push = admit_ok || (is_tick && pend_valid_q);
  assign qctl.rd   = is_tick && tick_runs;
  assign qctl.pop  = (state_q == S_TRD) && (fin || pre);
  assign push_id   = admit_ok ? in_id : pend_id_q;

  rrts_queue #(
    .MaxTasks(MAX_TASKS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (qctl),
    .push_id_i(push_id),
    .head_id_o(head_id),
    .count_o  (q_count)
  );

  // task record: remaining, burst, arrival
  assign t_rem     = t_rdata[RecW-1 -: BW];
  assign t_burst   = t_rdata[32 +: BW];
  assign t_arrival = t_rdata[31:0];
  assign rem_new   = t_rem - BW'(1);
  assign slice_new = slice_q + 8'd1;
  assign fin       = (rem_new == '0);
  assign pre       = !fin && (slice_new == quantum_q);

  assign t_we    = admit_ok || (state_q == S_TRD);
  assign t_waddr = admit_ok ? in_id : id_q;
  assign t_wdata = admit_ok ? {in_b, in_b, time_q} : {rem_new, t_burst, t_arrival};

  rrts_ram #(
    .Width(RecW),
    .Depth(MAX_TASKS)
  ) u_tram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .re_i   (state_q == S_QRD),
    .raddr_i(head_id),
    .rdata_o(t_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    res_d = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          if (in_data_i.func == FuncAdmit) begin
            if (in_busy) begin
              res_d.status = StBusy;
            end else if (in_zero) begin
              res_d.status = StZero;
            end else begin
              res_d.status = StOk;
            end
            res_d.time_now = time_q;
          end else begin
            res_d.time_now = time_q + 32'd1;
          end
        end
      end
      S_TRD: begin
        res_d.ran        = 1'b1;
        res_d.running_id = 4'(id_q);
        res_d.finished   = fin;
        res_d.preempted  = pre;
        if (fin) begin
          res_d.finish_time = time_q;
          res_d.turnaround  = time_q - t_arrival;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
      if (res_q.finished) begin
        out_d.waiting = res_q.turnaround - 32'(burst_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      quantum_q    <= 8'd2;
      time_q       <= '0;
      slice_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
      active_q     <= '0;
      id_q         <= '0;
      burst_q      <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.func == FuncAdmit) begin
              if (admit_ok) begin
                active_q[in_id] <= 1'b1;
              end
              state_q <= S_DONE;
            end else begin
              time_q       <= time_q + 32'd1;
              pend_valid_q <= 1'b0;
              state_q      <= tick_runs ? S_QRD : S_DONE;
            end
          end
        end
        S_QRD: begin
          id_q    <= head_id;
          state_q <= S_TRD;
        end
        S_TRD: begin
          burst_q <= t_burst;
          if (fin) begin
            slice_q        <= '0;
            active_q[id_q] <= 1'b0;
          end else if (pre) begin
            slice_q      <= '0;
            pend_valid_q <= 1'b1;
            pend_id_q    <= id_q;
          end else begin
            slice_q <= slice_new;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fin_pre_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.finished && out_data_o.preempted))
    else $error("task reported both finished and preempted");

  a_idle_tick_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ran) |->
      (!out_data_o.finished && !out_data_o.preempted && out_data_o.waiting == '0))
    else $error("result without a running task reports completion data");

  a_pend_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> active_q[pend_id_q])
    else $error("preempted task awaiting requeue is not active");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while previous item in flight");

endmodule

`default_nettype wire

/* design/rrts_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module rrts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/rrts_queue.sv */
// Circular ready queue of task ids: head/count pointers over a RAM,
// with forwarding when a push to an empty queue is read in the same cycle.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

module rrts_queue
  import rrts_pkg::*;
#(
  parameter int MaxTasks = MaxTasksDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rrts_qctl_t                    ctl_i,
  input  wire logic [$clog2(MaxTasks)-1:0]   push_id_i,
  output logic      [$clog2(MaxTasks)-1:0]   head_id_o,
  output logic      [$clog2(MaxTasks+1)-1:0] count_o
);

  localparam int IdW  = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  logic [IdW-1:0]  head_q;
  logic [CntW-1:0] count_q;
  logic            fwd_q;
  logic [IdW-1:0]  fwd_id_q;
  logic [IdW:0]    tail_sum;
  logic [IdW-1:0]  tail;
  logic [IdW-1:0]  rdata;

  // head + count stays below twice the depth: one compare and subtract
  assign tail_sum = (IdW+1)'(head_q) + (IdW+1)'(count_q);
  always_comb begin
    if (tail_sum >= (IdW+1)'(MaxTasks)) begin
      tail = IdW'(tail_sum - (IdW+1)'(MaxTasks));
    end else begin
      tail = tail_sum[IdW-1:0];
    end
  end

  rrts_ram #(
    .Width(IdW),
    .Depth(MaxTasks)
  ) u_qram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.push),
    .waddr_i(tail),
    .wdata_i(push_id_i),
    .re_i   (ctl_i.rd),
    .raddr_i(head_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      fwd_q    <= 1'b0;
      fwd_id_q <= '0;
    end else begin
      if (ctl_i.pop) begin
        if (head_q == IdW'(MaxTasks - 1)) begin
          head_q <= '0;
        end else begin
          head_q <= head_q + IdW'(1);
        end
      end
      count_q  <= count_q + CntW'(ctl_i.push) - CntW'(ctl_i.pop);
      // pushed entry is the head when the queue was empty
      fwd_q    <= ctl_i.rd && ctl_i.push && (count_q == '0);
      fwd_id_q <= push_id_i;
    end
  end

  assign head_id_o = fwd_q ? fwd_id_q : rdata;
  assign count_o   = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> (count_q != CntW'(MaxTasks)))
    else $error("push into a full ready queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> (count_q != '0))
    else $error("pop from an empty ready queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTasks))
    else $error("ready queue count beyond depth");

endmodule

`default_nettype wire
